/* rtl/core/wbps_pkg.sv */
`timescale 1ns / 1ps
// Shared types, register indexes and pattern helpers for the wildcard byte
// pattern scanner. No dependencies.
package wbps_pkg;

   localparam int CSR_INDEX_BITS = 8;
   localparam int CSR_DATA_BITS  = 64;
   localparam int PATTERN_BITS   = 64;
   localparam int MASK_BITS      = 16;
   localparam int LENGTH_BITS    = 5;
   localparam int REG_BYTES      = 16;
   localparam int LOW_BYTES      = 8;

   typedef logic [7:0]                byte_type;
   typedef logic [CSR_INDEX_BITS-1:0] csr_index_type;
   typedef logic [CSR_DATA_BITS-1:0]  csr_data_type;
   typedef logic [PATTERN_BITS-1:0]   pattern_type;
   typedef logic [MASK_BITS-1:0]      mask_type;
   typedef logic [LENGTH_BITS-1:0]    length_type;

   localparam csr_index_type CSR_PATTERN_LOW    = 8'd0;
   localparam csr_index_type CSR_PATTERN_HIGH   = 8'd1;
   localparam csr_index_type CSR_WILDCARD_MASK  = 8'd2;
   localparam csr_index_type CSR_PATTERN_LENGTH = 8'd3;

   localparam length_type LENGTH_RESET = 5'd1;

   // Bytes past the two pattern registers read as zero.
   function automatic byte_type pattern_byte(pattern_type lo, pattern_type hi,
                                             int unsigned i);
      byte_type b;
      if (i < LOW_BYTES) begin
         b = lo[8*i +: 8];
      end else if (i < REG_BYTES) begin
         b = hi[8*(i-LOW_BYTES) +: 8];
      end else begin
         b = '0;
      end
      return b;
   endfunction

   // Bytes past the mask are never wildcards.
   function automatic logic is_wildcard(mask_type m, int unsigned i);
      logic w;
      if (i < MASK_BITS) begin
         w = m[i];
      end else begin
         w = 1'b0;
      end
      return w;
   endfunction

endpackage

/* rtl/core/wbps_channels.sv */
`timescale 1ns / 1ps
// Valid/ready channel interfaces of the scanner: byte input, result output
// and register write. Depends on wbps_pkg.
interface wbps_req_if;
   import wbps_pkg::*;
   logic     valid;
   logic     ready;
   byte_type data_byte;
   logic     last_byte;
   modport source (output valid, output data_byte, output last_byte, input ready);
   modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

interface wbps_rsp_if #(parameter int OFFSET_BITS = 32);
   logic                   valid;
   logic                   ready;
   logic                   found;
   logic [OFFSET_BITS-1:0] match_offset;
   modport source (output valid, output found, output match_offset, input ready);
   modport sink (input valid, input found, input match_offset, output ready);
endinterface

interface wbps_csr_if;
   import wbps_pkg::*;
   logic          valid;
   logic          ready;
   csr_index_type reg_index;
   csr_data_type  wdata;
   modport source (output valid, output reg_index, output wdata, input ready);
   modport sink (input valid, input reg_index, input wdata, output ready);
endinterface

/* rtl/core/wildcard_byte_pattern_scanner_core.sv */
`timescale 1ns / 1ps
// Wildcard byte pattern scanner, top level.
// Depends on wbps_pkg and the channel interfaces in wbps_channels.sv.
//
// Software writes the pattern bytes, the wildcard mask and the pattern length
// through the csr channel (always ready) while the scanner is idle. The region
// to search streams in on req_ch, one byte per transaction, last_byte set on
// its final byte. At the first match rsp_ch carries one transaction with found
// set and the start offset of the match; a region that ends with no match gives
// one transaction with found clear and offset zero. Nothing else is reported.
// A byte is taken every cycle unless rsp_ch stalls: the window shifts on
// acceptance, the compare runs in the following cycle from the window
// register, and the result register loads on the next edge once it is free.
// When rsp_ch stalls, the result register holds, the compare stage holds
// behind it and req_ch ready drops until they drain.
// A byte counter that reaches its maximum stops the search for the region.
// Reset clears the registers to their defaults (length one), the counter and
// both stages, and marks the region ended so the first byte flushes the window.
module wildcard_byte_pattern_scanner_core #(
   parameter int MAX_PATTERN_BYTES = 16,
   parameter int OFFSET_BITS       = 32
) (
   input  logic        clock,
   input  logic        reset,
   wbps_csr_if.sink    csr_ch,
   wbps_req_if.sink    req_ch,
   wbps_rsp_if.source  rsp_ch
);
   import wbps_pkg::*;

   localparam int LEN_BITS     = $clog2(MAX_PATTERN_BYTES + 1);
   localparam int WIN_IDX_BITS = (MAX_PATTERN_BYTES > 1) ? $clog2(MAX_PATTERN_BYTES) : 1;
   localparam logic [LEN_BITS-1:0]    LEN_MAX   = LEN_BITS'(MAX_PATTERN_BYTES);
   localparam logic [OFFSET_BITS-1:0] COUNT_MAX = '1;

   pattern_type pattern_low_ff, pattern_low_in;
   pattern_type pattern_high_ff, pattern_high_in;
   mask_type    wildcard_mask_ff, wildcard_mask_in;
   length_type  pattern_length_ff, pattern_length_in;

   byte_type               window_ff [MAX_PATTERN_BYTES];
   byte_type               window_in [MAX_PATTERN_BYTES];
   logic                   region_end_ff, region_end_in;
   logic [OFFSET_BITS-1:0] bytes_seen_ff, bytes_seen_in;
   logic                   match_reported_ff, match_reported_in;

   logic                   s1_valid_ff, s1_valid_in;
   logic                   s1_last_ff, s1_last_in;
   logic                   s1_open_ff, s1_open_in;
   logic [OFFSET_BITS-1:0] s1_idx_ff, s1_idx_in;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   rsp_found_ff, rsp_found_in;
   logic [OFFSET_BITS-1:0] rsp_offset_ff, rsp_offset_in;

   logic                   req_accept;
   logic                   count_open;
   logic [LEN_BITS-1:0]    len_used;
   logic                   window_hit;
   logic [OFFSET_BITS-1:0] s1_count;
   logic [OFFSET_BITS-1:0] len_wide;
   logic                   s1_enough;
   logic                   s1_hit;
   logic                   s1_emit;
   logic                   s1_go;

   // Register writes
   assign csr_ch.ready = 1'b1;

   always_comb begin
      pattern_low_in    = pattern_low_ff;
      pattern_high_in   = pattern_high_ff;
      wildcard_mask_in  = wildcard_mask_ff;
      pattern_length_in = pattern_length_ff;
      if (csr_ch.valid) begin
         case (csr_ch.reg_index)
            CSR_PATTERN_LOW:    pattern_low_in    = csr_ch.wdata[PATTERN_BITS-1:0];
            CSR_PATTERN_HIGH:   pattern_high_in   = csr_ch.wdata[PATTERN_BITS-1:0];
            CSR_WILDCARD_MASK:  wildcard_mask_in  = csr_ch.wdata[MASK_BITS-1:0];
            CSR_PATTERN_LENGTH: pattern_length_in = csr_ch.wdata[LENGTH_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      if (pattern_length_ff == '0) begin
         len_used = LEN_BITS'(1);
      end else if (int'(pattern_length_ff) > MAX_PATTERN_BYTES) begin
         len_used = LEN_MAX;
      end else begin
         len_used = LEN_BITS'(pattern_length_ff);
      end
   end

   // Input side: shift window, advance counter
   assign req_accept = req_ch.valid && req_ch.ready;
   assign count_open = bytes_seen_ff != COUNT_MAX;

   always_comb begin
      window_in = window_ff;
      if (req_accept) begin
         for (int k = MAX_PATTERN_BYTES - 1; k > 0; k--) begin
            window_in[k] = region_end_ff ? 8'h00 : window_ff[k-1];
         end
         window_in[0] = req_ch.data_byte;
      end
   end

   always_comb begin
      region_end_in = region_end_ff;
      bytes_seen_in = bytes_seen_ff;
      s1_last_in    = s1_last_ff;
      s1_open_in    = s1_open_ff;
      s1_idx_in     = s1_idx_ff;
      if (req_accept) begin
         region_end_in = req_ch.last_byte;
         s1_last_in    = req_ch.last_byte;
         s1_open_in    = count_open;
         s1_idx_in     = bytes_seen_ff;
         if (req_ch.last_byte) begin
            bytes_seen_in = '0;
         end else if (count_open) begin
            bytes_seen_in = bytes_seen_ff + OFFSET_BITS'(1);
         end
      end
   end

   // Compare stage
   always_comb begin
      logic [WIN_IDX_BITS-1:0] sel;
      window_hit = 1'b1;
      for (int i = 0; i < MAX_PATTERN_BYTES; i++) begin
         sel = WIN_IDX_BITS'(int'(len_used) - 1 - i);
         if (i < int'(len_used) && !is_wildcard(wildcard_mask_ff, i) &&
             window_ff[sel] != pattern_byte(pattern_low_ff, pattern_high_ff, i)) begin
            window_hit = 1'b0;
         end
      end
   end

   assign s1_count  = s1_idx_ff + OFFSET_BITS'(1);
   assign len_wide  = OFFSET_BITS'(len_used);
   assign s1_enough = s1_count >= len_wide;
   assign s1_hit    = s1_valid_ff && s1_open_ff && !match_reported_ff && s1_enough &&
                      window_hit;
   assign s1_emit   = s1_hit || (s1_last_ff && !match_reported_ff);
   assign s1_go     = s1_valid_ff && (!rsp_valid_ff || rsp_ch.ready);

   assign req_ch.ready = !s1_valid_ff || s1_go;

   always_comb begin
      s1_valid_in       = s1_valid_ff;
      match_reported_in = match_reported_ff;
      if (s1_go) begin
         s1_valid_in       = 1'b0;
         match_reported_in = s1_last_ff ? 1'b0 : (match_reported_ff || s1_hit);
      end
      if (req_accept) begin
         s1_valid_in = 1'b1;
      end
   end

   // Result register
   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_found_in  = rsp_found_ff;
      rsp_offset_in = rsp_offset_ff;
      if (s1_go && s1_emit) begin
         rsp_valid_in  = 1'b1;
         rsp_found_in  = s1_hit;
         rsp_offset_in = s1_hit ? (s1_count - len_wide) : '0;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.found        = rsp_found_ff;
   assign rsp_ch.match_offset = rsp_offset_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         pattern_low_ff    <= '0;
         pattern_high_ff   <= '0;
         wildcard_mask_ff  <= '0;
         pattern_length_ff <= LENGTH_RESET;
         region_end_ff     <= 1'b1;
         bytes_seen_ff     <= '0;
         match_reported_ff <= 1'b0;
         s1_valid_ff       <= 1'b0;
         rsp_valid_ff      <= 1'b0;
      end else begin
         pattern_low_ff    <= pattern_low_in;
         pattern_high_ff   <= pattern_high_in;
         wildcard_mask_ff  <= wildcard_mask_in;
         pattern_length_ff <= pattern_length_in;
         region_end_ff     <= region_end_in;
         bytes_seen_ff     <= bytes_seen_in;
         match_reported_ff <= match_reported_in;
         s1_valid_ff       <= s1_valid_in;
         rsp_valid_ff      <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      window_ff     <= window_in;
      s1_last_ff    <= s1_last_in;
      s1_open_ff    <= s1_open_in;
      s1_idx_ff     <= s1_idx_in;
      rsp_found_ff  <= rsp_found_in;
      rsp_offset_ff <= rsp_offset_in;
   end

`ifndef NO_ASSERTIONS
   a_not_found_offset_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_found_ff |-> rsp_offset_ff == '0)
      else $error("not-found result with nonzero offset");

   a_stall_only_behind_stage: assert property (@(posedge clock) disable iff (reset)
      !req_ch.ready |-> s1_valid_ff && rsp_valid_ff && !rsp_ch.ready)
      else $error("input stalled without a held transaction");

   a_hit_marks_reported: assert property (@(posedge clock) disable iff (reset)
      s1_go && s1_hit && !s1_last_ff |=> match_reported_ff)
      else $error("match not recorded after report");

   a_last_clears_counter: assert property (@(posedge clock) disable iff (reset)
      req_accept && req_ch.last_byte |=> bytes_seen_ff == '0)
      else $error("byte counter not cleared at end of region");

   a_single_report: assert property (@(posedge clock) disable iff (reset)
      match_reported_ff |-> !s1_hit)
      else $error("second match reported in one region");
`endif

endmodule

/* test/wbps_scan_checker.sv */
`timescale 1ns / 1ps
// Scoreboard for wildcard_byte_pattern_scanner_core: tracks register writes and accepted
// bytes, predicts each scan result and compares it with the accepted result transactions.
// Depends on wbps_pkg.
module wbps_scan_checker #(
   parameter int OFFSET_BITS = 32,
   parameter int MAX_BYTES   = 16
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    csr_valid,
   input  logic                    csr_ready,
   input  wbps_pkg::csr_index_type csr_index,
   input  wbps_pkg::csr_data_type  csr_wdata,
   input  logic                    req_valid,
   input  logic                    req_ready,
   input  wbps_pkg::byte_type      req_data_byte,
   input  logic                    req_last_byte,
   input  logic                    rsp_valid,
   input  logic                    rsp_ready,
   input  logic                    rsp_found,
   input  logic [OFFSET_BITS-1:0]  rsp_match_offset,
   output int                      fail_count,
   output int                      pending
);
   import wbps_pkg::*;

   typedef struct packed {
      logic                   found;
      logic [OFFSET_BITS-1:0] offset;
   } scan_hit_type;

   scan_hit_type           expected_hits[$];
   byte_type               recent_bytes[MAX_BYTES];
   logic [OFFSET_BITS-1:0] scan_count;
   logic                   hit_reported;
   pattern_type            pat_lo;
   pattern_type            pat_hi;
   mask_type               wild_mask;
   length_type             pat_len;
   int                     mismatches = 0;

   function automatic void clear_scan();
      for (int i = 0; i < MAX_BYTES; i++) begin
         recent_bytes[i] = '0;
      end
      scan_count   = '0;
      hit_reported = 1'b0;
   endfunction

   function automatic bit scan_step(input byte_type b, input logic last,
                                    output scan_hit_type hit);
      logic [2*PATTERN_BITS-1:0] pat;
      int unsigned               span;
      logic [OFFSET_BITS-1:0]    start_pos;
      bit                        emit;
      bit                        same;
      pat = {pat_hi, pat_lo};
      span = (pat_len == 0) ? 1 : ((pat_len > MAX_BYTES) ? MAX_BYTES : pat_len);
      start_pos = scan_count;
      emit = 1'b0;
      hit = '0;
      for (int i = MAX_BYTES - 1; i > 0; i--) begin
         recent_bytes[i] = recent_bytes[i-1];
      end
      recent_bytes[0] = b;
      if (scan_count != '1) begin
         scan_count = scan_count + 1'b1;
         if (!hit_reported && scan_count >= span) begin
            same = 1'b1;
            for (int unsigned i = 0; i < span; i++) begin
               if (i >= REG_BYTES) begin
                  if (recent_bytes[span-1-i] != 8'h00) same = 1'b0;
               end else if (!wild_mask[i] && recent_bytes[span-1-i] != pat[8*i +: 8]) begin
                  same = 1'b0;
               end
            end
            if (same) begin
               hit_reported = 1'b1;
               hit.found    = 1'b1;
               hit.offset   = start_pos + OFFSET_BITS'(1) - OFFSET_BITS'(span);
               emit         = 1'b1;
            end
         end
      end
      if (last) begin
         if (!hit_reported) begin
            hit  = '0;
            emit = 1'b1;
         end
         clear_scan();
      end
      return emit;
   endfunction

   always @(posedge clock) begin
      scan_hit_type want;
      scan_hit_type got;
      if (reset) begin
         clear_scan();
         pat_lo    = '0;
         pat_hi    = '0;
         wild_mask = '0;
         pat_len   = LENGTH_RESET;
         expected_hits.delete();
         pending    <= 0;
         fail_count <= mismatches;
      end else begin
         if (rsp_valid && rsp_ready) begin
            got.found  = rsp_found;
            got.offset = rsp_match_offset;
            if (expected_hits.size() == 0) begin
               if (mismatches < 10) begin
                  $display("unexpected result: found=%0d offset=%0d", got.found, got.offset);
               end
               mismatches++;
            end else begin
               want = expected_hits.pop_front();
               if (got.found !== want.found || got.offset !== want.offset) begin
                  if (mismatches < 10) begin
                     $display("result mismatch: found exp=%0d act=%0d, offset exp=%0d act=%0d",
                              want.found, got.found, want.offset, got.offset);
                  end
                  mismatches++;
               end
            end
         end
         if (req_valid && req_ready) begin
            if (scan_step(req_data_byte, req_last_byte, want)) expected_hits.push_back(want);
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_PATTERN_LOW:    pat_lo    = csr_wdata;
               CSR_PATTERN_HIGH:   pat_hi    = csr_wdata;
               CSR_WILDCARD_MASK:  wild_mask = csr_wdata[MASK_BITS-1:0];
               CSR_PATTERN_LENGTH: pat_len   = csr_wdata[LENGTH_BITS-1:0];
               default: ;
            endcase
         end
         pending    <= expected_hits.size();
         fail_count <= mismatches;
      end
   end

endmodule

/* test/tb_wildcard_byte_pattern_scanner_core.sv */
`timescale 1ns / 1ps
// Testbench top for wildcard_byte_pattern_scanner_core: clock, reset, register writes and
// byte regions with random idling on both channels; verdict from wbps_scan_checker.
// Depends on wbps_pkg, wbps_channels.sv and wbps_scan_checker.sv.
module tb_wildcard_byte_pattern_scanner_core;
   import wbps_pkg::*;

   localparam int OFFSET_W     = 32;
   localparam int MAX_BYTES    = 16;
   localparam int IDLE_LIMIT   = 2000;
   localparam int DRAIN_CYCLES = 4;
   localparam int RANDOM_BYTES = 650;

   logic        clock;
   logic        reset;
   int          fail_count;
   int          pending;
   bit          steady = 1'b0;
   int          sent = 0;
   int          idle_cycles = 0;
   pattern_type cur_low = '0;
   pattern_type cur_high = '0;
   mask_type    cur_mask = '0;
   length_type  cur_len = LENGTH_RESET;

   wbps_req_if                           req_ch();
   wbps_rsp_if #(.OFFSET_BITS(OFFSET_W)) rsp_ch();
   wbps_csr_if                           csr_ch();

   wildcard_byte_pattern_scanner_core #(
      .MAX_PATTERN_BYTES(MAX_BYTES),
      .OFFSET_BITS(OFFSET_W)
   ) dut (
      .clock(clock),
      .reset(reset),
      .csr_ch(csr_ch),
      .req_ch(req_ch),
      .rsp_ch(rsp_ch)
   );

   wbps_scan_checker #(
      .OFFSET_BITS(OFFSET_W),
      .MAX_BYTES(MAX_BYTES)
   ) scan_check (
      .clock(clock),
      .reset(reset),
      .csr_valid(csr_ch.valid),
      .csr_ready(csr_ch.ready),
      .csr_index(csr_ch.reg_index),
      .csr_wdata(csr_ch.wdata),
      .req_valid(req_ch.valid),
      .req_ready(req_ch.ready),
      .req_data_byte(req_ch.data_byte),
      .req_last_byte(req_ch.last_byte),
      .rsp_valid(rsp_ch.valid),
      .rsp_ready(rsp_ch.ready),
      .rsp_found(rsp_ch.found),
      .rsp_match_offset(rsp_ch.match_offset),
      .fail_count(fail_count),
      .pending(pending)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (steady || r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 96) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   task automatic send_byte(input byte_type b, input logic last);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid     <= 1'b1;
      req_ch.data_byte <= b;
      req_ch.last_byte <= last;
      do @(posedge clock); while (!req_ch.ready);
      sent++;
   endtask

   task automatic send_bytes(input byte_type q[$], input bit close);
      for (int k = 0; k < q.size(); k++) begin
         send_byte(q[k], close && (k == q.size() - 1));
      end
   endtask

   // Leaves csr valid high; the caller drops it after its batch of writes.
   task automatic write_reg(input csr_index_type idx, input csr_data_type val);
      csr_ch.valid     <= 1'b1;
      csr_ch.reg_index <= idx;
      csr_ch.wdata     <= val;
      do @(posedge clock); while (!csr_ch.ready);
      case (idx)
         CSR_PATTERN_LOW:    cur_low  = val;
         CSR_PATTERN_HIGH:   cur_high = val;
         CSR_WILDCARD_MASK:  cur_mask = val[MASK_BITS-1:0];
         CSR_PATTERN_LENGTH: cur_len  = val[LENGTH_BITS-1:0];
         default: ;
      endcase
   endtask

   // Hold input until every predicted result is out and the pipeline is empty.
   task automatic settle();
      req_ch.valid <= 1'b0;
      csr_ch.valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic random_config(input int phase);
      csr_data_type lo;
      csr_data_type hi;
      csr_data_type m;
      csr_data_type l;
      int           r;
      lo = {$urandom, $urandom};
      hi = {$urandom, $urandom};
      m  = {$urandom, $urandom};
      l  = {$urandom, $urandom};
      r = $urandom_range(0, 99);
      if (r < 30) m[15:0] = '0;
      else if (r < 40) m[15:0] = '1;
      else m[15:0] = 16'($urandom & $urandom);
      r = $urandom_range(0, 99);
      if (r < 55) l[4:0] = 5'($urandom_range(1, 4));
      else if (r < 72) l[4:0] = 5'($urandom_range(5, 15));
      else if (r < 82) l[4:0] = 5'd16;
      else if (r < 88) l[4:0] = 5'd0;
      else l[4:0] = 5'($urandom_range(17, 31));
      case (phase)
         0: begin
            l[4:0]  = 5'd16;
            m[15:0] = '1;
         end
         1: begin
            l[4:0]  = 5'd31;
            lo      = '1;
            hi      = '1;
            m[15:0] = '0;
         end
         2: begin
            l[4:0] = 5'd1;
            lo     = '0;
            hi     = '0;
         end
         3: l[4:0] = 5'd0;
         default: ;
      endcase
      if ($urandom_range(0, 7) == 0) begin
         write_reg(csr_index_type'($urandom_range(4, 255)), {$urandom, $urandom});
      end
      write_reg(CSR_PATTERN_LOW, lo);
      write_reg(CSR_PATTERN_HIGH, hi);
      write_reg(CSR_WILDCARD_MASK, m);
      write_reg(CSR_PATTERN_LENGTH, l);
      csr_ch.valid <= 1'b0;
   endtask

   task automatic random_region();
      byte_type         region[$];
      logic [127:0]     pat;
      int unsigned      used;
      int unsigned      total;
      int unsigned      pos;
      int unsigned      kind;
      int unsigned      k;
      int               r;
      pat  = {cur_high, cur_low};
      used = (cur_len == 0) ? 1 : ((cur_len > MAX_BYTES) ? MAX_BYTES : cur_len);
      r = $urandom_range(0, 99);
      if (r < 10) total = $urandom_range(1, used);
      else if (r < 95) total = used + $urandom_range(0, 20);
      else total = $urandom_range(40, 90);
      for (k = 0; k < total; k++) begin
         if ($urandom_range(0, 2) == 0) region.push_back(byte_type'($urandom));
         else region.push_back(pat[8*$urandom_range(0, used - 1) +: 8]);
      end
      kind = $urandom_range(0, 9);
      if (kind < 7 && total >= used) begin
         pos = $urandom_range(0, total - used);
         for (k = 0; k < used; k++) begin
            if (!cur_mask[k]) region[pos+k] = pat[8*k +: 8];
         end
         // corrupt one byte of the planted copy
         if (kind >= 5) begin
            k = $urandom_range(0, used - 1);
            region[pos+k] = region[pos+k] ^ byte_type'(1 << $urandom_range(0, 7));
         end
      end
      for (k = 0; k < total; k++) begin
         if (k > 0 && $urandom_range(0, 39) == 0) settle();
         send_byte(region[k], k == total - 1);
      end
   endtask

   initial begin
      int run;
      int hold;
      rsp_ch.ready <= 1'b0;
      @(posedge clock);
      forever begin
         run = $urandom_range(1, 24);
         rsp_ch.ready <= 1'b1;
         repeat (run) @(posedge clock);
         hold = pick_gap();
         if (hold > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (hold) @(posedge clock);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
          (csr_ch.valid && csr_ch.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      int phase;
      int regions;
      reset            <= 1'b1;
      req_ch.valid     <= 1'b0;
      req_ch.data_byte <= '0;
      req_ch.last_byte <= 1'b0;
      csr_ch.valid     <= 1'b0;
      csr_ch.reg_index <= '0;
      csr_ch.wdata     <= '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      steady = 1'b1;
      send_bytes('{8'h55, 8'h00}, 1'b1);
      settle();
      write_reg(CSR_PATTERN_LOW, 64'h0000_0000_0022_3F11);
      write_reg(CSR_PATTERN_HIGH, 64'hFFFF_FFFF_FFFF_FFFF);
      write_reg(CSR_WILDCARD_MASK, 64'h0000_0000_ABCD_0000);
      write_reg(CSR_PATTERN_LENGTH, 64'hFFFF_FFFF_FFFF_FFE3);
      csr_ch.valid <= 1'b0;
      send_bytes('{8'h11, 8'h44, 8'h22, 8'h11, 8'h3F, 8'h22}, 1'b1);
      settle();
      write_reg(CSR_WILDCARD_MASK, 64'h0000_0000_0000_0002);
      csr_ch.valid <= 1'b0;
      send_bytes('{8'h11, 8'h99, 8'h22, 8'h00}, 1'b1);
      send_bytes('{8'hFF, 8'hFF}, 1'b1);
      settle();
      write_reg(CSR_PATTERN_LOW, 64'hFFFF_FFFF_FFFF_FFAB);
      write_reg(CSR_PATTERN_LENGTH, 64'h0000_0000_0000_0000);
      csr_ch.valid <= 1'b0;
      send_bytes('{8'h00, 8'hAB}, 1'b1);
      settle();
      write_reg(CSR_PATTERN_LOW, 64'h0000_0000_0000_0077);
      write_reg(CSR_PATTERN_LENGTH, 64'h0000_0000_0000_0021);
      csr_ch.valid <= 1'b0;
      send_bytes('{8'h10, 8'h20}, 1'b0);
      settle();
      write_reg(CSR_PATTERN_LOW, 64'h0000_0000_0000_0020);
      csr_ch.valid <= 1'b0;
      send_bytes('{8'h20}, 1'b1);

      sent = 0;
      for (phase = 0; sent < RANDOM_BYTES; phase++) begin
         settle();
         steady = (phase % 5 == 4);
         random_config(phase);
         regions = $urandom_range(3, 6);
         repeat (regions) random_region();
      end
      settle();

      if (fail_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

/* sim.f */
rtl/core/wbps_pkg.sv
rtl/core/wbps_channels.sv
rtl/core/wildcard_byte_pattern_scanner_core.sv
test/wbps_scan_checker.sv
test/tb_wildcard_byte_pattern_scanner_core.sv
